// ----- rtl/lcd4_pkg.sv -----
// ----------------------------------------------------------------------------
// lcd4_pkg
// Shared types, codes and constants of the 4-bit character-LCD sequencer.
// ----------------------------------------------------------------------------
package lcd4_pkg;

    // clipping limit on the number of rows
    localparam logic [2:0] MAX_ROWS = 3'd4;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // command codes
    localparam logic [2:0] FN_PUTCHAR  = 3'd0;
    localparam logic [2:0] FN_LOCATION = 3'd1;
    localparam logic [2:0] FN_CLEAR    = 3'd2;
    localparam logic [2:0] FN_DISPCTRL = 3'd3;
    localparam logic [2:0] FN_CGSEL    = 3'd4;
    localparam logic [2:0] FN_CGROW    = 3'd5;
    localparam logic [2:0] FN_INIT     = 3'd6;

    // configuration register indexes
    localparam logic [2:0] REG_ROW_COUNT = 3'd0;
    localparam logic [2:0] REG_COL_COUNT = 3'd1;
    localparam logic [2:0] REG_ROW0_ADDR = 3'd2;
    localparam logic [2:0] REG_ROW1_ADDR = 3'd3;
    localparam logic [2:0] REG_ROW2_ADDR = 3'd4;
    localparam logic [2:0] REG_ROW3_ADDR = 3'd5;

    // register reset values
    localparam logic [2:0] RST_ROW_COUNT = 3'd4;
    localparam logic [5:0] RST_COL_COUNT = 6'd20;
    localparam logic [6:0] RST_ROW0_ADDR = 7'h00;
    localparam logic [6:0] RST_ROW1_ADDR = 7'h40;
    localparam logic [6:0] RST_ROW2_ADDR = 7'h14;
    localparam logic [6:0] RST_ROW3_ADDR = 7'h54;
    localparam logic [7:0] RST_BITMAP    = 8'h08;

    // command bytes
    localparam logic [7:0] CMD_SET_DDRAM = 8'h80;
    localparam logic [7:0] CMD_CLEAR     = 8'h01;
    localparam logic [7:0] CMD_FUNC_SET  = 8'h28;
    localparam logic [7:0] CMD_DISP_OFF  = 8'h08;
    localparam logic [7:0] CMD_ENTRY     = 8'h06;
    localparam logic [7:0] CTRL_DISPLAY  = 8'h04;
    localparam logic [3:0] NIB_WAKE      = 4'h3;
    localparam logic [3:0] NIB_4BIT      = 4'h2;

    // waits in microseconds
    localparam logic [12:0] WAIT_HIGH       = 13'd1;
    localparam logic [12:0] WAIT_LOW        = 13'd54;
    localparam logic [12:0] WAIT_CLEAR_LOW  = 13'd1574;
    localparam logic [12:0] WAIT_ICLEAR_LOW = 13'd2214;
    localparam logic [12:0] WAIT_POWER1     = 13'd5001;
    localparam logic [12:0] WAIT_POWER2     = 13'd201;

    localparam logic [3:0] INIT_LAST_STEP = 4'd13;

    typedef struct packed {
        logic [2:0] func;
        logic [7:0] char_code;
        logic [7:0] target_row;
        logic [7:0] target_column;
        logic [2:0] control_bits;
        logic       turn_on;
        logic [2:0] glyph_code;
    } t_in;

    typedef struct packed {
        logic        register_select;
        logic [3:0]  nibble;
        logic [12:0] wait_after_us;
        logic        last;
    } t_out;

    typedef struct packed {
        logic [2:0]      row_count;
        logic [5:0]      column_count;
        logic [3:0][6:0] row_address;
    } t_cfg;

    // one queued job: a single byte, or the whole init sequence
    typedef struct packed {
        logic        is_init;
        logic        rs;
        logic [7:0]  data;
        logic [12:0] wait_low;
    } t_job;

    // init sequence, final byte is the display-control bitmap
    function automatic t_out init_nibble(input logic [3:0] step, input logic [7:0] fin);
        t_out o;
        o.register_select = 1'b0;
        o.last            = (step == INIT_LAST_STEP);
        case (step)
            4'd0:    begin o.nibble = NIB_WAKE;           o.wait_after_us = WAIT_POWER1;     end
            4'd1:    begin o.nibble = NIB_WAKE;           o.wait_after_us = WAIT_POWER2;     end
            4'd2:    begin o.nibble = NIB_WAKE;           o.wait_after_us = WAIT_LOW;        end
            4'd3:    begin o.nibble = NIB_4BIT;           o.wait_after_us = WAIT_LOW;        end
            4'd4:    begin o.nibble = CMD_FUNC_SET[7:4];  o.wait_after_us = WAIT_HIGH;       end
            4'd5:    begin o.nibble = CMD_FUNC_SET[3:0];  o.wait_after_us = WAIT_LOW;        end
            4'd6:    begin o.nibble = CMD_DISP_OFF[7:4];  o.wait_after_us = WAIT_HIGH;       end
            4'd7:    begin o.nibble = CMD_DISP_OFF[3:0];  o.wait_after_us = WAIT_LOW;        end
            4'd8:    begin o.nibble = CMD_CLEAR[7:4];     o.wait_after_us = WAIT_HIGH;       end
            4'd9:    begin o.nibble = CMD_CLEAR[3:0];     o.wait_after_us = WAIT_ICLEAR_LOW; end
            4'd10:   begin o.nibble = CMD_ENTRY[7:4];     o.wait_after_us = WAIT_HIGH;       end
            4'd11:   begin o.nibble = CMD_ENTRY[3:0];     o.wait_after_us = WAIT_LOW;        end
            4'd12:   begin o.nibble = fin[7:4];           o.wait_after_us = WAIT_HIGH;       end
            4'd13:   begin o.nibble = fin[3:0];           o.wait_after_us = WAIT_LOW;        end
            default: begin o.nibble = 4'h0;               o.wait_after_us = 13'd0;           end
        endcase
        return o;
    endfunction

endpackage

// ----- rtl/lcd4_regs.sv -----
// ----------------------------------------------------------------------------
// lcd4_regs
// APB-style configuration registers: clipping size and row start addresses.
// ----------------------------------------------------------------------------
module lcd4_regs (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [4:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output lcd4_pkg::t_cfg   o_cfg
);

    lcd4_pkg::t_cfg r_cfg;
    logic [2:0]     w_index;
    logic           w_write;

    assign w_index = paddr[4:2];
    assign w_write = psel & penable & pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.row_count      <= lcd4_pkg::RST_ROW_COUNT;
            r_cfg.column_count   <= lcd4_pkg::RST_COL_COUNT;
            r_cfg.row_address[0] <= lcd4_pkg::RST_ROW0_ADDR;
            r_cfg.row_address[1] <= lcd4_pkg::RST_ROW1_ADDR;
            r_cfg.row_address[2] <= lcd4_pkg::RST_ROW2_ADDR;
            r_cfg.row_address[3] <= lcd4_pkg::RST_ROW3_ADDR;
        end else if (w_write) begin
            unique case (w_index)
                lcd4_pkg::REG_ROW_COUNT: r_cfg.row_count      <= pwdata[2:0];
                lcd4_pkg::REG_COL_COUNT: r_cfg.column_count   <= pwdata[5:0];
                lcd4_pkg::REG_ROW0_ADDR: r_cfg.row_address[0] <= pwdata[6:0];
                lcd4_pkg::REG_ROW1_ADDR: r_cfg.row_address[1] <= pwdata[6:0];
                lcd4_pkg::REG_ROW2_ADDR: r_cfg.row_address[2] <= pwdata[6:0];
                lcd4_pkg::REG_ROW3_ADDR: r_cfg.row_address[3] <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_index)
            lcd4_pkg::REG_ROW_COUNT: prdata = {29'd0, r_cfg.row_count};
            lcd4_pkg::REG_COL_COUNT: prdata = {26'd0, r_cfg.column_count};
            lcd4_pkg::REG_ROW0_ADDR: prdata = {25'd0, r_cfg.row_address[0]};
            lcd4_pkg::REG_ROW1_ADDR: prdata = {25'd0, r_cfg.row_address[1]};
            lcd4_pkg::REG_ROW2_ADDR: prdata = {25'd0, r_cfg.row_address[2]};
            lcd4_pkg::REG_ROW3_ADDR: prdata = {25'd0, r_cfg.row_address[3]};
            default:                 prdata = 32'd0;
        endcase
    end

endmodule

// ----- rtl/lcd4_front.sv -----
// ----------------------------------------------------------------------------
// lcd4_front
// Accepts commands, tracks cursor and display-control state, clips against
// the visible area and turns each command into at most one queued job.
// ----------------------------------------------------------------------------
module lcd4_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  lcd4_pkg::t_cfg  i_cfg,
    input  logic            i_accept,
    input  lcd4_pkg::t_in   i_cmd,
    output logic            o_push,
    output lcd4_pkg::t_job  o_job
);

    logic [7:0] r_cursor_row, n_cursor_row;
    logic [7:0] r_cursor_col, n_cursor_col;
    logic [7:0] r_bitmap, n_bitmap;
    logic [2:0] w_rows;
    logic [7:0] w_ctrl_mask;
    logic [7:0] w_loc_addr;
    logic       w_cur_vis;
    logic       w_loc_vis;
    logic       w_emit;

    assign w_rows = (i_cfg.row_count > lcd4_pkg::MAX_ROWS) ? lcd4_pkg::MAX_ROWS
                                                          : i_cfg.row_count;
    assign w_cur_vis = (r_cursor_row < {5'd0, w_rows}) &&
                       (r_cursor_col < {2'd0, i_cfg.column_count});
    assign w_loc_vis = (i_cmd.target_row < {5'd0, w_rows}) &&
                       (i_cmd.target_column < {2'd0, i_cfg.column_count});
    assign w_loc_addr  = {1'b0, i_cfg.row_address[i_cmd.target_row[1:0]]}
                         + i_cmd.target_column;
    assign w_ctrl_mask = {5'd0, i_cmd.control_bits};

    always_comb begin
        n_cursor_row  = r_cursor_row;
        n_cursor_col  = r_cursor_col;
        n_bitmap      = r_bitmap;
        w_emit        = 1'b0;
        o_job.is_init  = 1'b0;
        o_job.rs       = 1'b0;
        o_job.data     = 8'h00;
        o_job.wait_low = lcd4_pkg::WAIT_LOW;
        unique case (i_cmd.func)
            lcd4_pkg::FN_PUTCHAR: begin
                w_emit       = w_cur_vis;
                o_job.rs     = 1'b1;
                o_job.data   = i_cmd.char_code;
                if (w_cur_vis) n_cursor_col = r_cursor_col + 8'd1;
            end
            lcd4_pkg::FN_LOCATION: begin
                n_cursor_row = i_cmd.target_row;
                n_cursor_col = i_cmd.target_column;
                w_emit       = w_loc_vis;
                o_job.data   = w_loc_addr | lcd4_pkg::CMD_SET_DDRAM;
            end
            lcd4_pkg::FN_CLEAR: begin
                n_cursor_row   = 8'd0;
                n_cursor_col   = 8'd0;
                w_emit         = 1'b1;
                o_job.data     = lcd4_pkg::CMD_CLEAR;
                o_job.wait_low = lcd4_pkg::WAIT_CLEAR_LOW;
            end
            lcd4_pkg::FN_DISPCTRL: begin
                n_bitmap   = i_cmd.turn_on ? (r_bitmap | w_ctrl_mask)
                                           : (r_bitmap & ~w_ctrl_mask);
                w_emit     = 1'b1;
                o_job.data = n_bitmap;
            end
            lcd4_pkg::FN_CGSEL: begin
                w_emit     = 1'b1;
                o_job.data = {2'b01, i_cmd.glyph_code, 3'b000};
            end
            lcd4_pkg::FN_CGROW: begin
                w_emit     = 1'b1;
                o_job.rs   = 1'b1;
                o_job.data = i_cmd.char_code;
            end
            lcd4_pkg::FN_INIT: begin
                // final step of init switches the display on
                n_bitmap      = r_bitmap | lcd4_pkg::CTRL_DISPLAY;
                w_emit        = 1'b1;
                o_job.is_init = 1'b1;
                o_job.data    = n_bitmap;
            end
            default: ;
        endcase
    end

    assign o_push = i_accept & w_emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor_row <= 8'd0;
            r_cursor_col <= 8'd0;
            r_bitmap     <= lcd4_pkg::RST_BITMAP;
        end else if (i_accept) begin
            r_cursor_row <= n_cursor_row;
            r_cursor_col <= n_cursor_col;
            r_bitmap     <= n_bitmap;
        end
    end

endmodule

// ----- rtl/lcd4_queue.sv -----
// ----------------------------------------------------------------------------
// lcd4_queue
// Small job queue between front and back, push and pop in the same cycle.
// ----------------------------------------------------------------------------
module lcd4_queue #(
    parameter int P_DEPTH = lcd4_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  lcd4_pkg::t_job  i_job,
    input  logic            i_pop,
    output lcd4_pkg::t_job  o_job,
    output logic            o_empty,
    output logic            o_full
);

    localparam int PW = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int CW = $clog2(P_DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(P_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(P_DEPTH);

    lcd4_pkg::t_job r_mem [P_DEPTH];
    logic [PW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]  r_count;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == FULL_CNT);
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            if (i_pop)  r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            if (i_push && !i_pop)      r_count <= r_count + 1'b1;
            else if (!i_push && i_pop) r_count <= r_count - 1'b1;
        end
    end

endmodule

// ----- rtl/lcd4_back.sv -----
// ----------------------------------------------------------------------------
// lcd4_back
// Nibble sequencer: walks the head job one transfer per cycle, while the
// output is not stalled, into a registered output stage.
// ----------------------------------------------------------------------------
module lcd4_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  lcd4_pkg::t_job  i_job,
    input  logic            i_empty,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_stall,
    output lcd4_pkg::t_out  o_data
);

    logic [3:0]     r_step;
    logic           r_valid;
    lcd4_pkg::t_out r_data;
    lcd4_pkg::t_out w_nib;
    logic           w_advance;
    logic           w_load;

    always_comb begin
        if (i_job.is_init) begin
            w_nib = lcd4_pkg::init_nibble(r_step, i_job.data);
        end else begin
            w_nib.register_select = i_job.rs;
            w_nib.last            = r_step[0];
            w_nib.nibble          = r_step[0] ? i_job.data[3:0] : i_job.data[7:4];
            w_nib.wait_after_us   = r_step[0] ? i_job.wait_low : lcd4_pkg::WAIT_HIGH;
        end
    end

    assign w_advance = !r_valid || !i_stall;
    assign w_load    = w_advance && !i_empty;
    assign o_pop     = w_load && w_nib.last;
    assign o_valid   = r_valid;
    assign o_data    = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= 4'd0;
            r_valid <= 1'b0;
        end else if (w_advance) begin
            r_valid <= !i_empty;
            if (w_load) r_step <= w_nib.last ? 4'd0 : r_step + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) r_data <= w_nib;
    end

endmodule

// ----- rtl/char_lcd_4bit_command_sequencer.sv -----
// ----------------------------------------------------------------------------
// char_lcd_4bit_command_sequencer
// Character-LCD commands in, HD44780 4-bit nibble transfers with waits out.
// ----------------------------------------------------------------------------
//  channel   direction  handshake               payload
//  command   in         i_in_valid/o_in_stall   i_in_data  (t_in)
//  nibble    out        o_out_valid/i_out_stall o_out_data (t_out)
//  config    in         psel/penable/pwrite     paddr, pwdata, prdata
//
//  a byte command gives two transfers, init gives fourteen; the back
//  sequencer drives one nibble per cycle, while the output is not stalled,
//  into its output register. a command is accepted every cycle while the job
//  queue has room; clipped commands leave no job. the queue decouples input
//  from output stalls. reset is synchronous.
// ----------------------------------------------------------------------------
module char_lcd_4bit_command_sequencer #(
    parameter int P_QUEUE_DEPTH = lcd4_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  lcd4_pkg::t_in   i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output lcd4_pkg::t_out  o_out_data,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [4:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);

    lcd4_pkg::t_cfg w_cfg;
    lcd4_pkg::t_job w_push_job, w_head_job;
    logic           w_accept, w_push, w_pop, w_empty, w_full;

    assign o_in_stall = w_full;
    assign w_accept   = i_in_valid & ~w_full;

    lcd4_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    lcd4_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_accept (w_accept),
        .i_cmd    (i_in_data),
        .o_push   (w_push),
        .o_job    (w_push_job)
    );

    lcd4_queue #(
        .P_DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .i_pop   (w_pop),
        .o_job   (w_head_job),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    lcd4_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (w_head_job),
        .i_empty (w_empty),
        .o_pop   (w_pop),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (o_out_data)
    );

endmodule
